@@ hw/rtl/blt_pkg.sv @@
`default_nettype none
package blt_pkg;

    // voltage breakpoints, 0% .. 100% in equal percentage segments
    localparam int TABLE_POINTS = 11;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int SEG_W        = $clog2(TABLE_POINTS - 1);
    localparam int SEG_PCT      = 100 / (TABLE_POINTS - 1);
    localparam int MV_W         = 13;
    localparam int PCT_W        = 7;
    localparam int DIV_W        = 13;

    localparam logic [MV_W-1:0] VOLT_TABLE [TABLE_POINTS] = '{
        13'd3300, 13'd3610, 13'd3700, 13'd3773, 13'd3822, 13'd3866,
        13'd3910, 13'd3957, 13'd4000, 13'd4050, 13'd4200
    };

    // mV per 1% inside each segment: span / SEG_PCT, rounded down
    localparam logic [MV_W-1:0] SEG_STEP [TABLE_POINTS-1] = '{
        13'd31, 13'd9, 13'd7, 13'd4, 13'd4, 13'd4, 13'd4, 13'd4, 13'd5, 13'd15
    };

    typedef enum logic [2:0] {
        ACT_UPDATE = 3'd0,
        ACT_INIT   = 3'd1,
        ACT_FIRE   = 3'd2,
        ACT_EMPTY  = 3'd3,
        ACT_FULL   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        CFG_CHARGE_OFFSET = 3'd0,
        CFG_DISPLAY_STEP  = 3'd1,
        CFG_FULL_HOLD     = 3'd2,
        CFG_RISE_HOLD     = 3'd3,
        CFG_FIRE_PER_PCT  = 3'd4,
        CFG_UNDERVOLT     = 3'd5
    } cfg_idx_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_POST  = 7'b0010000,
        ST_SNAP  = 7'b0100000,
        ST_APPLY = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/blt_div.sv @@
`default_nettype none
module blt_div #(
    parameter int W = blt_pkg::DIV_W
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = shifted - {1'b0, dvs_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ hw/rtl/battery_level_tracker_unit.sv @@
`default_nettype none
// Battery level tracker: each input word carries an idle cell voltage, the charger flags
// and an action; each word gives one result word with the shown level, the real level,
// the table level and a charging refresh flag. Words are handled one at a time: fire
// tick, force empty, force full and unused actions skip the table; an update below or
// above the table skips the scan; inside the table it walks one breakpoint per cycle
// and then waits on the 13-step serial divider. An init also runs the divider to snap
// the table level down to a multiple of the display step, unless that step is zero; the
// segment division and the snap share one serial divider. A finished result sits in an
// output register, so the next input word is taken while it waits; a word that finishes
// while that register is still held waits in its last step until the receiver takes
// the earlier result. Configuration writes are taken in any cycle.
module battery_level_tracker_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // idle_mv [12:0], charging [13], hw_full [14], sw_full [15]
    input  wire logic [15:0] s_tdata,
    // action [2:0]
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // shown_level [6:0], real_level_out [13:7], table_level [20:14],
    // refresh_event [21], zero [23:22]
    output logic [23:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import blt_pkg::*;

    // configuration
    logic [9:0]      offset_reg;
    logic [5:0]      step_reg;
    logic [15:0]     full_hold_reg;
    logic [15:0]     rise_hold_reg;
    logic [15:0]     fire_pp_reg;
    logic [MV_W-1:0] uv_reg;

    // tracking state
    logic [PCT_W-1:0] real_reg, real_next;
    logic [PCT_W-1:0] shown_reg, shown_next;
    logic [15:0]      cc_reg, cc_next;
    logic [15:0]      fc_reg, fc_next;
    logic             ev_next;

    // per-word working registers
    state_t           state_reg;
    logic [2:0]       action_reg;
    logic [MV_W-1:0]  idle_reg;
    logic [MV_W-1:0]  mv_reg;
    logic             chg_reg, hw_reg, sw_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [PCT_W-1:0] tbl_reg;
    logic [PCT_W-1:0] snap_reg;

    logic [23:0] m_tdata_reg;
    logic        m_tvalid_reg;

    // divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dividend, div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_q;

    logic [MV_W-1:0]  in_idle, in_mv, off_ext;
    logic             in_chg;
    logic [SEG_W-1:0] scan_seg;
    logic [MV_W-1:0]  scan_step;
    logic [PCT_W:0]   seg_base, sub_pct, lvl_sum;
    logic [PCT_W-1:0] lvl;
    logic [DIV_W+5:0] snap_prod;
    logic [15:0]      cc_inc;
    logic [PCT_W:0]   st8, sh_sum, re_sum;
    logic [PCT_W-1:0] st7;
    logic             big, low;
    logic             out_free;

    blt_div #(.W(DIV_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_idle  = s_tdata[MV_W-1:0];
    assign in_chg   = s_tdata[13];
    assign off_ext  = {3'b000, offset_reg};
    assign in_mv    = !in_chg ? in_idle : ((in_idle > off_ext) ? in_idle - off_ext : '0);

    assign scan_seg  = SEG_W'(idx_reg - IDX_W'(1));
    assign scan_step = SEG_STEP[scan_seg];

    // interpolated level from the finished segment division, sub capped at one segment
    assign seg_base = (PCT_W+1)'(seg_reg) * (PCT_W+1)'(SEG_PCT);
    assign sub_pct  = (div_q > DIV_W'(SEG_PCT)) ? (PCT_W+1)'(SEG_PCT)
                                                : (PCT_W+1)'(div_q);
    assign lvl_sum  = seg_base + sub_pct;
    assign lvl      = (lvl_sum > (PCT_W+1)'(100)) ? PCT_W'(100) : lvl_sum[PCT_W-1:0];

    assign snap_prod = div_q * {{DIV_W{1'b0}}, step_reg};

    always_comb begin
        div_start    = 1'b0;
        div_dividend = mv_reg - VOLT_TABLE[scan_seg];
        div_divisor  = scan_step;
        if (state_reg == ST_SCAN) begin
            div_start = (mv_reg <= VOLT_TABLE[idx_reg]) && (scan_step != '0);
        end else if (state_reg == ST_POST) begin
            div_start    = (action_reg == ACT_INIT) && (step_reg != '0);
            div_dividend = DIV_W'(tbl_reg);
            div_divisor  = DIV_W'(step_reg);
        end
    end

    // level update for the word in hand
    always_comb begin
        real_next  = real_reg;
        shown_next = shown_reg;
        cc_next    = cc_reg;
        fc_next    = fc_reg;
        ev_next    = 1'b0;
        big        = 1'b0;
        low        = 1'b0;
        st7        = {1'b0, step_reg};
        st8        = {2'b00, step_reg};
        cc_inc     = (cc_reg != 16'hFFFF) ? cc_reg + 16'd1 : cc_reg;
        sh_sum     = '0;
        re_sum     = '0;
        case (action_reg)
            ACT_UPDATE: begin
                if (chg_reg) begin
                    if (hw_reg || sw_reg) begin
                        cc_next = cc_inc;
                        if (cc_inc >= full_hold_reg) begin
                            cc_next = '0;
                            if (shown_reg < PCT_W'(100)) begin
                                if (real_reg < PCT_W'(100)) real_next = real_reg + PCT_W'(1);
                                ev_next = 1'b1;
                            end
                        end
                    end else if (tbl_reg > real_reg) begin
                        cc_next = cc_inc;
                        if (cc_inc >= rise_hold_reg) begin
                            cc_next = '0;
                            if (shown_reg < PCT_W'(99)) begin
                                if (real_reg < PCT_W'(100)) real_next = real_reg + PCT_W'(1);
                                ev_next = 1'b1;
                            end
                        end
                    end else begin
                        cc_next = '0;
                    end
                    sh_sum = {1'b0, shown_reg} + st8;
                    re_sum = {1'b0, real_next} + st8;
                    if (real_next > shown_reg) begin
                        if (sh_sum <= {1'b0, real_next}) shown_next = sh_sum[PCT_W-1:0];
                        if (re_sum > (PCT_W+1)'(100) && (!hw_reg || !sw_reg))
                            shown_next = PCT_W'(100) - st7;
                    end
                end else if (shown_reg != '0 && fc_reg >= fire_pp_reg) begin
                    real_next = (real_reg >= PCT_W'(2)) ? real_reg - PCT_W'(1) : PCT_W'(1);
                    fc_next   = fc_reg - fire_pp_reg;
                    if (real_next < shown_reg) begin
                        big = (shown_reg > st7) && (real_next < shown_reg - st7);
                        low = ({1'b0, shown_reg} <= st8 + (PCT_W+1)'(1))
                              && (real_next == PCT_W'(1));
                        if (big || low)
                            shown_next = (shown_reg > st7) ? shown_reg - st7 : '0;
                        if (idle_reg > uv_reg && shown_next <= st7) shown_next = st7;
                    end
                end
            end
            ACT_INIT: begin
                real_next  = snap_reg;
                shown_next = snap_reg;
            end
            ACT_FIRE: begin
                fc_next = (fc_reg != 16'hFFFF) ? fc_reg + 16'd1 : fc_reg;
            end
            ACT_EMPTY: begin
                real_next  = '0;
                shown_next = '0;
            end
            ACT_FULL: begin
                real_next  = PCT_W'(100);
                shown_next = PCT_W'(100);
            end
            default: begin
            end
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            real_reg     <= '0;
            shown_reg    <= '0;
            cc_reg       <= '0;
            fc_reg       <= '0;
        end else begin
            if (state_reg == ST_APPLY && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    if (action_reg != ACT_UPDATE && action_reg != ACT_INIT) begin
                        state_reg <= ST_APPLY;
                    end else if (mv_reg <= VOLT_TABLE[0]) begin
                        state_reg <= ST_POST;
                    end else if (mv_reg > VOLT_TABLE[TABLE_POINTS-1]) begin
                        state_reg <= ST_POST;
                    end else begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (mv_reg <= VOLT_TABLE[idx_reg]) begin
                        state_reg <= (scan_step != '0) ? ST_DIV : ST_POST;
                    end
                end
                ST_DIV: begin
                    if (div_done) state_reg <= ST_POST;
                end
                ST_POST: begin
                    state_reg <= div_start ? ST_SNAP : ST_APPLY;
                end
                ST_SNAP: begin
                    if (div_done) state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (out_free) begin
                        real_reg     <= real_next;
                        shown_reg    <= shown_next;
                        cc_reg       <= cc_next;
                        fc_reg       <= fc_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // per-word payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                action_reg <= s_tuser;
                idle_reg   <= in_idle;
                mv_reg     <= in_mv;
                chg_reg    <= in_chg;
                hw_reg     <= s_tdata[14];
                sw_reg     <= s_tdata[15];
                idx_reg    <= IDX_W'(1);
                tbl_reg    <= '0;
            end
            ST_PREP: begin
                // only update and init look the voltage up
                if ((action_reg == ACT_UPDATE || action_reg == ACT_INIT) &&
                    mv_reg > VOLT_TABLE[TABLE_POINTS-1]) tbl_reg <= PCT_W'(100);
            end
            ST_SCAN: begin
                seg_reg <= scan_seg;
                if (mv_reg <= VOLT_TABLE[idx_reg]) begin
                    // zero-step segment adds nothing beyond its base
                    if (scan_step == '0)
                        tbl_reg <= PCT_W'((PCT_W+1)'(scan_seg) * (PCT_W+1)'(SEG_PCT));
                end else begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            ST_DIV: begin
                if (div_done) tbl_reg <= lvl;
            end
            ST_POST: begin
                snap_reg <= tbl_reg;
            end
            ST_SNAP: begin
                if (div_done) snap_reg <= snap_prod[PCT_W-1:0];
            end
            ST_APPLY: begin
                if (out_free)
                    m_tdata_reg <= {2'b00, ev_next, tbl_reg, real_next, shown_next};
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            step_reg      <= 6'd5;
            full_hold_reg <= 16'd1;
            rise_hold_reg <= 16'd1;
            fire_pp_reg   <= 16'd1;
            uv_reg        <= 13'd3300;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHARGE_OFFSET: offset_reg    <= cfg_data[9:0];
                CFG_DISPLAY_STEP:  step_reg      <= cfg_data[5:0];
                CFG_FULL_HOLD:     full_hold_reg <= cfg_data;
                CFG_RISE_HOLD:     rise_hold_reg <= cfg_data;
                CFG_FIRE_PER_PCT:  fire_pp_reg   <= cfg_data;
                CFG_UNDERVOLT:     uv_reg        <= cfg_data[MV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire
